FILE: hw/rtl/s7e_pkg.sv
// Shared types, constants and helpers for the seven-byte to 14-bit text encoder.
package s7e_pkg;

   localparam int unsigned GROUP_LEN   = 7;
   localparam int unsigned GROUP_BITS  = 8 * GROUP_LEN;
   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [15:0] CODE_OFFSET = 16'h4E00;
   localparam logic [7:0]  MARK_CHAR   = 8'h3D;

   localparam logic [2:0]  FULL_COUNT  = 3'd7;

   // One group handed from the front to the back: bytes left-aligned,
   // zero-padded, with the number of real bytes and the stream-end flag.
   typedef struct packed {
      logic [GROUP_BITS-1:0] data;
      logic [2:0]            count;
      logic                  last;
   } job_type;

   // Number of code bytes sent for a group of the given byte count.
   function automatic logic [3:0] code_len(input logic [2:0] count);
      logic [3:0] len;
      unique case (count)
         3'd1:    len = 4'd2;
         3'd2:    len = 4'd4;
         3'd3:    len = 4'd4;
         3'd4:    len = 4'd6;
         3'd5:    len = 4'd6;
         3'd6:    len = 4'd8;
         3'd7:    len = 4'd8;
         default: len = 4'd0;
      endcase
      return len;
   endfunction

endpackage

FILE: hw/rtl/s7e_front.sv
// Front end: gathers input bytes into groups and issues one job per group.
module s7e_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_data_byte,
   input  logic              req_last_byte,
   output logic              job_valid,
   input  logic              job_ready,
   output s7e_pkg::job_type  job
);
   import s7e_pkg::*;

   localparam int unsigned HELD_MAX = GROUP_LEN - 1;

   logic [7:0] lane_ff [HELD_MAX];
   logic [7:0] lane_in [HELD_MAX];
   logic [2:0] count_ff;
   logic [2:0] count_in;
   logic [2:0] next_count;
   logic       flush;
   logic       accept;

   assign next_count = count_ff + 3'd1;
   assign flush      = (next_count == FULL_COUNT) || req_last_byte;
   assign req_ready  = job_ready;
   assign accept     = req_valid && req_ready;
   assign job_valid  = req_valid && flush;

   // Assemble the left-aligned group; lanes above the count are zero.
   always_comb begin
      job.data = '0;
      for (int j = 0; j < HELD_MAX; j++) begin
         job.data[GROUP_BITS-1-8*j -: 8] = (count_ff == 3'(j)) ? req_data_byte : lane_ff[j];
      end
      job.data[7:0] = (count_ff == 3'(HELD_MAX)) ? req_data_byte : 8'h00;
      job.count     = next_count;
      job.last      = req_last_byte;
   end

   always_comb begin
      count_in = count_ff;
      for (int j = 0; j < HELD_MAX; j++) begin
         lane_in[j] = lane_ff[j];
      end
      if (accept) begin
         if (flush) begin
            count_in = 3'd0;
            for (int j = 0; j < HELD_MAX; j++) begin
               lane_in[j] = 8'h00;
            end
         end else begin
            count_in = next_count;
            for (int j = 0; j < HELD_MAX; j++) begin
               if (count_ff == 3'(j)) begin
                  lane_in[j] = req_data_byte;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
         for (int j = 0; j < HELD_MAX; j++) begin
            lane_ff[j] <= 8'h00;
         end
      end else begin
         count_ff <= count_in;
         for (int j = 0; j < HELD_MAX; j++) begin
            lane_ff[j] <= lane_in[j];
         end
      end
   end

endmodule

FILE: hw/rtl/s7e_queue.sv
// Small job queue between the front end and the back end.
module s7e_queue #(
   parameter int unsigned DEPTH = s7e_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  s7e_pkg::job_type  in_job,
   output logic              out_valid,
   input  logic              out_ready,
   output s7e_pkg::job_type  out_job
);
   import s7e_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CNT_FULL);
   assign out_valid = (count_ff != '0);
   assign out_job   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

FILE: hw/rtl/s7e_back.sv
// Back end: turns one job into code bytes and, for a partial group, the tail marker and the count byte.
module s7e_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  s7e_pkg::job_type  job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_code_byte,
   output logic              rsp_run_end,
   output logic              rsp_stream_end
);
   import s7e_pkg::*;

   job_type     cur_ff;
   logic        busy_ff;
   logic [3:0]  idx_ff;
   logic [3:0]  n_code;
   logic [3:0]  n_total;
   logic        full_group;
   logic [13:0] value;
   logic [15:0] word;
   logic        transfer;
   logic        done;

   assign full_group = (cur_ff.count == FULL_COUNT);
   assign n_code     = code_len(cur_ff.count);
   assign n_total    = full_group ? n_code : n_code + 4'd2;

   // Pick the 14-bit value for this byte slot and offset it.
   always_comb begin
      unique case (idx_ff[2:1])
         2'd0:    value = cur_ff.data[55:42];
         2'd1:    value = cur_ff.data[41:28];
         2'd2:    value = cur_ff.data[27:14];
         default: value = cur_ff.data[13:0];
      endcase
      word = {2'b00, value} + CODE_OFFSET;
   end

   always_comb begin
      if (idx_ff < n_code) begin
         rsp_code_byte = idx_ff[0] ? word[7:0] : word[15:8];
      end else if (idx_ff == n_code) begin
         rsp_code_byte = MARK_CHAR;
      end else begin
         rsp_code_byte = {5'd0, cur_ff.count};
      end
   end

   assign rsp_valid      = busy_ff;
   assign rsp_run_end    = (idx_ff == n_total - 4'd1);
   assign rsp_stream_end = rsp_run_end && (!full_group || cur_ff.last);
   assign transfer       = rsp_valid && rsp_ready;
   assign done           = transfer && rsp_run_end;
   assign job_ready      = !busy_ff || done;

   always_ff @(posedge clock) begin
      if (job_valid && job_ready) begin
         cur_ff <= job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 4'd0;
      end else if (job_ready) begin
         busy_ff <= job_valid;
         idx_ff  <= 4'd0;
      end else if (transfer) begin
         idx_ff  <= idx_ff + 4'd1;
      end
   end

endmodule

FILE: hw/rtl/seven_byte_to_14bit_text_encoder_top.sv
// Top level of the seven-byte to 14-bit text encoder.
//
// The encoder takes one raw byte per req_ transfer and returns encoded bytes
// one per rsp_ transfer. Seven input bytes form a group, read big-endian as
// four 14-bit values; each value plus 0x4E00 leaves as two bytes, high byte
// first. A byte flagged req_last_byte closes the stream: a partial group of
// k bytes is zero-padded, its first 2, 4, 4, 6, 6 or 8 code bytes are sent,
// then '=' and the byte k. rsp_run_end marks the last byte caused by one
// input byte, rsp_stream_end the final byte of a stream. Bytes that do not
// close a group cause no output. Timing: the front end takes a byte in every
// cycle while the job queue (QUEUE_DEPTH groups) has room; a group leaves
// the back end at one byte per cycle while rsp_ready is high, with no gap
// between groups, so a full group sends 8 bytes and a tail 4 to 10. The
// sustained input rate is therefore set by the output port. A closing
// byte's group is registered in the job queue and then in the back end
// before its first output byte appears.
module seven_byte_to_14bit_text_encoder_top #(
   parameter int unsigned QUEUE_DEPTH = s7e_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_code_byte,
   output logic       rsp_run_end,
   output logic       rsp_stream_end
);
   import s7e_pkg::*;

   job_type front_job;
   job_type back_job;
   logic    front_valid;
   logic    front_ready;
   logic    back_valid;
   logic    back_ready;

   // Gather bytes; issue a job when a group fills or the stream ends.
   s7e_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .job_valid     (front_valid),
      .job_ready     (front_ready),
      .job           (front_job)
   );

   // Hold finished groups so the front keeps accepting while output stalls.
   s7e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_job    (front_job),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_job   (back_job)
   );

   // Advance through the code bytes of one group per job.
   s7e_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (back_valid),
      .job_ready      (back_ready),
      .job            (back_job),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_byte  (rsp_code_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_stream_end (rsp_stream_end)
   );

endmodule
